// File: rtl/array_list_engine_core_macros.svh
// Assertion macros for the array list engine.
// Used by the top level; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define ALE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine_core: check failed");

// next-cycle implication
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine_core: check failed");

`endif

// File: rtl/ale_pkg.sv
// Shared types and constants for the array list engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    localparam int unsigned CAPACITY_DEF = 64;
    localparam logic [6:0]  LIMIT_RESET  = 7'd64;

    localparam int unsigned IN_TDATA_W   = 40;  // value, position
    localparam int unsigned IN_TUSER_W   = 3;   // cmd
    localparam int unsigned OUT_TDATA_W  = 16;  // result_position, list_length
    localparam int unsigned OUT_TUSER_W  = 3;   // status, found
    localparam int unsigned LIMIT_W      = 7;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_SEARCH = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_INSERT = 3'd3;
    localparam logic [2:0] CMD_SORTED = 3'd4;
    localparam logic [2:0] CMD_FIND   = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT_R,
        S_SHIFT_L,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/ale_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/array_list_engine_core.sv
// Array list engine: packed list of signed 32-bit values in one RAM, one command per transaction.
// Append, clear, unused command and most errors go straight from dispatch to the result stage;
// search / find walk the list; inserts and removes shift entries, sorted inserts do both.
// Throughput: one transaction at a time, a new command is taken only back in idle; the worst case is
// a find miss that walks the whole list, then shifts all of it, bounded by the single RAM port.
// Reset (sync, active low): list length 0, capacity limit 64; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_core #(
    parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: capacity_limit
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ale_pkg::LIMIT_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ale_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], position[37:32]
    input  wire logic [ale_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // cmd[2:0]
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [ale_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // result_position[5:0], list_length[12:6]
    output logic [ale_pkg::OUT_TUSER_W-1:0]      m_axis_tuser   // status[1:0], found[2]
);

    import ale_pkg::*;

    `include "array_list_engine_core_macros.svh"

    localparam int unsigned AW   = $clog2(CAPACITY);      // RAM address
    localparam int unsigned CW   = $clog2(CAPACITY + 1);  // count / index, holds CAPACITY
    localparam int unsigned CMPW = (CW > 7) ? CW : 7;     // common width for compares
    localparam logic [CW-1:0]   CAP_C = CW'(CAPACITY);
    localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state                r_state, n_state;
    logic [2:0]            r_cmd, n_cmd;
    logic signed [31:0]    r_val, n_val;
    logic [5:0]            r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [LIMIT_W-1:0]    r_limit, n_limit;
    logic [CW-1:0]         r_idx, n_idx;       // next RAM read index
    logic                  r_pend, n_pend;     // RAM read in flight
    logic [CW-1:0]         r_paddr, n_paddr;   // scan: index read; shift: destination
    logic [CW-1:0]         r_slot, n_slot;     // first entry greater than value
    logic                  r_slot_ok, n_slot_ok;
    logic [1:0]            r_status, n_status;
    logic                  r_found, n_found;
    logic [CW-1:0]         r_rpos, n_rpos;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_status, n_out_status;
    logic                  r_out_found, n_out_found;
    logic [5:0]            r_out_rpos, n_out_rpos;
    logic [6:0]            r_out_len, n_out_len;

    // RAM port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [31:0]           mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [31:0]           mem_rdata;

    // helpers
    logic [CMPW-1:0]       cnt_x, lim_x, eff_x, pos_x, rpos_x;
    logic                  full;
    logic [CW-1:0]         pos_c, idx_m1;
    logic                  issue_scan, hit_eq, hit_gt;

    assign cnt_x  = CMPW'(r_count);
    assign lim_x  = CMPW'(r_limit);
    assign eff_x  = (lim_x < CAP_X) ? lim_x : CAP_X;
    assign full   = cnt_x >= eff_x;
    assign pos_x  = CMPW'(r_pos);
    assign pos_c  = CW'(r_pos);     // only used once pos <= count
    assign rpos_x = CMPW'(r_rpos);
    assign idx_m1 = r_idx - CW'(1);

    assign issue_scan = r_idx < r_count;
    assign hit_eq     = (mem_rdata == r_val);
    assign hit_gt     = !($signed(mem_rdata) <= r_val);

    ale_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_paddr      <= n_paddr;
        r_slot       <= n_slot;
        r_slot_ok    <= n_slot_ok;
        r_status     <= n_status;
        r_found      <= n_found;
        r_rpos       <= n_rpos;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_rpos   <= n_out_rpos;
        r_out_len    <= n_out_len;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_pos        = r_pos;
        n_count      = r_count;
        n_limit      = r_limit;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_paddr      = r_paddr;
        n_slot       = r_slot;
        n_slot_ok    = r_slot_ok;
        n_status     = r_status;
        n_found      = r_found;
        n_rpos       = r_rpos;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_rpos   = r_out_rpos;
        n_out_len    = r_out_len;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = mem_rdata;
        mem_raddr    = '0;

        // config writes must arrive only while idle; the block itself does not enforce this
        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser[2:0];
                    n_val   = s_axis_tdata[31:0];
                    n_pos   = s_axis_tdata[37:32];
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_status  = ST_OK;
                n_found   = 1'b0;
                n_rpos    = '0;
                n_idx     = '0;
                n_slot    = r_count;
                n_slot_ok = 1'b0;
                n_state   = S_DONE;
                case (r_cmd) inside
                    CMD_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = r_val;
                            n_rpos    = r_count;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    CMD_SEARCH, CMD_FIND: begin
                        n_state = S_SCAN;
                    end
                    CMD_SORTED: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_x >= cnt_x) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_rpos  = pos_c;
                            n_idx   = pos_c + CW'(1);
                            n_state = S_SHIFT_L;
                        end
                    end
                    CMD_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (pos_x > cnt_x) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_rpos  = pos_c;
                            n_idx   = r_count;
                            n_state = S_SHIFT_R;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // pipelined linear walk: issue index r_idx, check the entry read last cycle
            S_SCAN: begin
                mem_raddr = r_idx[AW-1:0];
                if (issue_scan) begin
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                    n_paddr = r_idx;
                end
                if (r_pend) begin
                    if (r_cmd != CMD_SORTED && hit_eq) begin
                        n_found = 1'b1;
                        n_rpos  = r_paddr;
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end else if (hit_gt && !r_slot_ok) begin
                        n_slot    = r_paddr;
                        n_slot_ok = 1'b1;
                        if (r_cmd == CMD_SORTED) begin
                            n_rpos  = r_paddr;
                            n_idx   = r_count;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT_R;
                        end
                    end
                end else if (!issue_scan) begin
                    // walked every entry without a match
                    if (r_cmd == CMD_SEARCH) begin
                        n_state = S_DONE;
                    end else if (r_cmd == CMD_FIND && full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_rpos  = r_slot;
                        n_idx   = r_count;
                        n_state = S_SHIFT_R;
                    end
                end
            end

            // open a hole at r_rpos: move entries up from the top, then drop the value in
            S_SHIFT_R: begin
                mem_raddr = idx_m1[AW-1:0];
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (r_idx > r_rpos) begin
                    n_pend  = 1'b1;
                    n_paddr = r_idx;
                    n_idx   = idx_m1;
                end else if (!r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rpos[AW-1:0];
                    mem_wdata = r_val;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end

            // close the gap at r_rpos: move later entries down by one
            S_SHIFT_L: begin
                mem_raddr = r_idx[AW-1:0];
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (issue_scan) begin
                    n_pend  = 1'b1;
                    n_paddr = idx_m1;
                    n_idx   = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_rpos   = rpos_x[5:0];
                    n_out_len    = cnt_x[6:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_len, r_out_rpos};
    assign m_axis_tuser  = {r_out_found, r_out_status};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ALE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CAP_C)
    `ALE_ASSERT_NOW(a_scan_no_write, r_state == S_SCAN, !mem_we)
    `ALE_ASSERT_NOW(a_shift_r_bound, r_state == S_SHIFT_R, r_idx >= r_rpos)
    `ALE_ASSERT_NEXT(a_accept_dispatch, s_axis_tvalid && s_axis_tready, r_state == S_DISPATCH)

endmodule

`default_nettype wire

// File: tb/sv/array_list_engine_core_checker.sv
// Checker for the array list engine: keeps a shadow copy of the list and the capacity limit,
// predicts every result transaction and compares it with what the block returns.
// Depends on ale_pkg.
`timescale 1ns / 1ps

module array_list_engine_core_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    input  wire logic                                  i_cfg_ready,
    input  wire logic [ale_pkg::LIMIT_W-1:0]           i_cfg_data,
    input  wire logic                                  i_s_tvalid,
    input  wire logic                                  i_s_tready,
    input  wire logic [ale_pkg::IN_TDATA_W-1:0]        i_s_tdata,  // value[31:0], position[37:32]
    input  wire logic [ale_pkg::IN_TUSER_W-1:0]        i_s_tuser,  // cmd[2:0]
    input  wire logic                                  i_m_tvalid,
    input  wire logic                                  i_m_tready,
    input  wire logic [ale_pkg::OUT_TDATA_W-1:0]       i_m_tdata,  // result_position[5:0], list_length[12:6]
    input  wire logic [ale_pkg::OUT_TUSER_W-1:0]       i_m_tuser,  // status[1:0], found[2]
    output int                                         o_fail_count,
    output int                                         o_pending
);

    import ale_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] position;
        logic [6:0] list_len;
    } list_result_t;

    logic [31:0]        shadow_list [CAPACITY_DEF];
    int unsigned        shadow_len   = 0;
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
    list_result_t       pending_results [$];
    int                 fail_total   = 0;

    // open a slot at idx by moving the tail one place right
    function automatic void place_at(input int unsigned idx, input logic [31:0] val);
        int unsigned k;
        for (k = shadow_len; k > idx; k--)
            shadow_list[k] = shadow_list[k-1];
        shadow_list[idx] = val;
        shadow_len++;
    endfunction

    function automatic list_result_t apply_list_command(input logic [2:0] cmd,
                                                        input logic [31:0] val,
                                                        input logic [5:0] pos);
        list_result_t r;
        int unsigned  lim, k, slot, hit_at;
        bit           hit, full;
        r      = '0;
        lim    = (shadow_limit < CAPACITY_DEF) ? shadow_limit : CAPACITY_DEF;
        full   = (shadow_len >= lim);
        hit    = 1'b0;
        hit_at = 0;
        for (k = 0; k < shadow_len; k++)
            if (!hit && shadow_list[k] == val) begin
                hit    = 1'b1;
                hit_at = k;
            end
        // sorted slot sits after every entry <= val (signed)
        slot = 0;
        while (slot < shadow_len && $signed(shadow_list[slot]) <= $signed(val))
            slot++;

        case (cmd)
            CMD_APPEND: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    r.position = shadow_len[5:0];
                    place_at(shadow_len, val);
                end
            end
            CMD_SEARCH: begin
                if (hit) begin
                    r.found    = 1'b1;
                    r.position = hit_at[5:0];
                end
            end
            CMD_REMOVE: begin
                if (pos >= shadow_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                    r.position = pos;
                end
            end
            CMD_INSERT: begin
                if (full)
                    r.status = ST_FULL;
                else if (pos > shadow_len)
                    r.status = ST_RANGE;
                else begin
                    place_at(pos, val);
                    r.position = pos;
                end
            end
            CMD_SORTED: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    place_at(slot, val);
                    r.position = slot[5:0];
                end
            end
            CMD_FIND: begin
                if (hit) begin
                    r.found    = 1'b1;
                    r.position = hit_at[5:0];
                end else if (full) begin
                    r.status = ST_FULL;
                end else begin
                    place_at(slot, val);
                    r.position = slot[5:0];
                end
            end
            CMD_CLEAR: shadow_len = 0;
            default: ;
        endcase
        r.list_len = shadow_len[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        list_result_t want, got;
        if (!i_rst_n) begin
            shadow_len   = 0;
            shadow_limit = LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                shadow_limit = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_list_command(i_s_tuser, i_s_tdata[31:0],
                                                             i_s_tdata[37:32]));
            if (i_m_tvalid && i_m_tready) begin
                got.status   = i_m_tuser[1:0];
                got.found    = i_m_tuser[2];
                got.position = i_m_tdata[5:0];
                got.list_len = i_m_tdata[12:6];
                if (pending_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result with nothing outstanding: status %0d found %0d pos %0d len %0d",
                                 $realtime, got.status, got.found, got.position, got.list_len);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.position !== want.position || got.list_len !== want.list_len) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: mismatch exp status %0d found %0d pos %0d len %0d, got status %0d found %0d pos %0d len %0d",
                                     $realtime, want.status, want.found, want.position,
                                     want.list_len, got.status, got.found, got.position,
                                     got.list_len);
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: tb/sv/array_list_engine_core_tb.sv
// Testbench top for array_list_engine_core: clock, reset, command stimulus, capacity writes
// and the verdict. Depends on ale_pkg, the block and array_list_engine_core_checker.
`timescale 1ns / 1ps

module array_list_engine_core_tb;

    import ale_pkg::*;

    // command code the block does not define; must leave the list alone
    localparam logic [2:0]  CMD_UNUSED  = 3'd7;
    localparam logic [31:0] INT_MIN_PAT = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_PAT = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [LIMIT_W-1:0]     i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value[31:0], position[37:32]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // cmd[2:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // result_position[5:0], list_length[12:6]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // status[1:0], found[2]

    int mismatch_total;
    int results_outstanding;
    bit steady = 1'b0;   // set for the closing stretch: no idling on either side

    array_list_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    array_list_engine_core_checker list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (mismatch_total),
        .o_pending    (results_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. Worst case is ~775 transactions, each a find miss that scans and then
    // shifts the whole list behind the longest input gap and result stall, about
    // 1.3 ms; this allows several times that.
    initial begin
        #10_000_000;
        $display("array_list_engine_core verification failed");
        $finish;
    end

    // Result side: random stall bursts, always ready once steady.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady) begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Values: half from a small pool so searches hit and sorted inserts see equal
    // keys, half fully random.
    function automatic logic [31:0] draw_value();
        logic [31:0] pool [8];
        pool = '{INT_MIN_PAT, INT_MAX_PAT, ALL_ONES, 32'd0, 32'd1, 32'd2, 32'd3, 32'd100};
        if ($urandom_range(0, 1))
            return pool[3'($urandom_range(0, 7))];
        return $urandom();
    endfunction

    // Positions: mostly near the head so removes and inserts usually land in range.
    function automatic logic [5:0] draw_position();
        if ($urandom_range(0, 1))
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 6));
    endfunction

    // One command transaction. Any idle burst comes before the item; valid stays up
    // after the handshake so the next call lowers or reloads it exactly once.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] val,
                                input logic [5:0] pos);
        if (!steady && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, pos, val};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop the stream and wait for every outstanding result to be accepted.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
    endtask

    // Capacity writes happen only with the block idle.
    task automatic write_capacity(input logic [LIMIT_W-1:0] lim);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random commands. A growth phase drops clear and thins out removes so the
    // list can reach the full 64 entries.
    task automatic run_phase(input int n_items, input bit growth);
        int          k, pick;
        logic [2:0]  cmd;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (growth)
                cmd = pick < 25 ? CMD_APPEND : pick < 40 ? CMD_SEARCH :
                      pick < 47 ? CMD_REMOVE : pick < 62 ? CMD_INSERT :
                      pick < 80 ? CMD_SORTED : pick < 97 ? CMD_FIND : CMD_UNUSED;
            else
                cmd = pick < 20 ? CMD_APPEND : pick < 35 ? CMD_SEARCH :
                      pick < 55 ? CMD_REMOVE : pick < 68 ? CMD_INSERT :
                      pick < 80 ? CMD_SORTED : pick < 92 ? CMD_FIND :
                      pick < 94 ? CMD_UNUSED : CMD_CLEAR;
            send_command(cmd, draw_value(), draw_position());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset limit of 64.
        send_command(CMD_REMOVE, 32'd0, 6'd0);          // remove from empty list
        send_command(CMD_SEARCH, 32'd5, 6'd0);          // search miss on empty list
        send_command(CMD_INSERT, 32'd9, 6'd1);          // insert past the length
        send_command(CMD_APPEND, INT_MAX_PAT, 6'd0);
        send_command(CMD_APPEND, INT_MIN_PAT, 6'd0);
        send_command(CMD_APPEND, 32'd0, 6'd0);
        send_command(CMD_APPEND, ALL_ONES, 6'd0);
        send_command(CMD_SEARCH, INT_MIN_PAT, 6'd0);    // hit at index 1
        send_command(CMD_SEARCH, 32'd12345, 6'd0);      // miss
        send_command(CMD_INSERT, 32'd7, 6'd4);          // insert right at the length
        send_command(CMD_INSERT, 32'd8, 6'd63);         // far out of range
        send_command(CMD_SORTED, 32'd0, 6'd0);          // lands at the head, before the first greater entry
        send_command(CMD_SORTED, INT_MIN_PAT, 6'd0);
        send_command(CMD_SORTED, INT_MAX_PAT, 6'd0);
        send_command(CMD_FIND, ALL_ONES, 6'd0);         // existing entry
        send_command(CMD_FIND, 32'd42, 6'd0);           // miss, sorted insert
        send_command(CMD_REMOVE, 32'd0, 6'd63);         // out of range
        send_command(CMD_REMOVE, 32'd0, 6'd0);          // head
        send_command(CMD_REMOVE, 32'd0, 6'd7);          // tail of the 8 left
        send_command(CMD_UNUSED, ALL_ONES, 6'd63);
        send_command(CMD_CLEAR, 32'd0, 6'd0);
        send_command(CMD_REMOVE, 32'd0, 6'd0);          // empty again
        send_command(CMD_SORTED, 32'h5555_5555, 6'h2A); // into an empty list
        send_command(CMD_SORTED, 32'hAAAA_AAAA, 6'h15);
        send_command(CMD_CLEAR, 32'd0, 6'd0);

        // Random part across capacity settings, extremes included.
        write_capacity(7'd3);
        run_phase(90, 1'b0);
        write_capacity(7'd0);       // every insertion reports full
        run_phase(40, 1'b0);
        write_capacity(7'd1);
        run_phase(60, 1'b0);
        write_capacity(7'd64);
        run_phase(200, 1'b1);
        write_capacity(7'd5);       // usually below the current length
        run_phase(60, 1'b0);
        write_capacity(7'd127);     // above the array size, clamps to 64
        run_phase(150, 1'b0);
        steady = 1'b1;
        write_capacity(7'($urandom_range(1, 64)));
        run_phase(150, 1'b0);

        drain_results();
        // longest command is a find miss that scans and then shifts
        repeat (150) @(posedge i_clk);
        if (mismatch_total == 0 && results_outstanding == 0)
            $display("array_list_engine_core verification clean");
        else
            $display("array_list_engine_core verification failed");
        $finish;
    end

endmodule

// File: array_list_engine_core.f
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/array_list_engine_core.sv
tb/sv/array_list_engine_core_checker.sv
tb/sv/array_list_engine_core_tb.sv
